// ----- hdl/bpm_pkg.sv -----
// ----------------------------------------------------------------------------
// bpm_pkg: shared types and helpers for the bounded precedes monitor
// Q16.16 robustness type with infinity codes, min/max helpers, register
// indexes and the sequencer-to-datapath control bundle.
// ----------------------------------------------------------------------------
package bpm_pkg;

  // Signed Q16.16 robustness value
  typedef logic signed [31:0] q_t;

  // Extreme codes stand for the infinities
  localparam q_t Q_POS_INF = 32'sh7FFF_FFFF;
  localparam q_t Q_NEG_INF = 32'sh8000_0000;

  // Configuration register indexes (word address bit 2)
  localparam logic REG_BOUND_BEGIN = 1'b0;
  localparam logic REG_BOUND_END   = 1'b1;

  // Datapath strobes issued by the sequencer
  typedef struct packed {
    logic load;      // shift new samples in, seed work copy and lanes
    logic min_step;  // one window step on every lane
    logic max_step;  // fold one lane into the running maximum
    logic out_load;  // move the finished result to the output register
  } ctrl_t;

  function automatic q_t q_min(input q_t a, input q_t b);
    return (a <= b) ? a : b;
  endfunction

  function automatic q_t q_max(input q_t a, input q_t b);
    return (a >= b) ? a : b;
  endfunction

endpackage

// ----- hdl/bpm_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpm_ctrl: sequencer of the bounded precedes monitor
// Steps the lanes through the window minimum, then folds them into the maximum
// one per cycle, then loads the output register; an empty window skips both.
// ----------------------------------------------------------------------------
module bpm_ctrl #(
  parameter int CntW = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic [CntW-1:0]   bnd_begin,
  input  logic [CntW-1:0]   bnd_end,
  input  logic              out_free,
  output logic              idle,
  output bpm_pkg::ctrl_t    ctrl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIN  = 2'd1;
  localparam logic [1:0] ST_MAX  = 2'd2;
  localparam logic [1:0] ST_HOLD = 2'd3;

  logic [1:0]      state;
  logic [1:0]      state_next;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] cnt_next;
  logic [CntW-1:0] lag_last;
  logic            empty_win;

  assign empty_win = bnd_begin > bnd_end;
  assign lag_last  = CntW'(bnd_end - bnd_begin);
  assign idle      = (state == ST_IDLE);

  // Next state and step counter
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    ctrl.load     = 1'b0;
    ctrl.min_step = 1'b0;
    ctrl.max_step = 1'b0;
    ctrl.out_load = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          ctrl.load  = 1'b1;
          cnt_next   = '0;
          state_next = empty_win ? ST_HOLD : ST_MIN;
        end
      end
      ST_MIN: begin
        ctrl.min_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == bnd_end) begin
          cnt_next   = '0;
          state_next = ST_MAX;
        end
      end
      ST_MAX: begin
        ctrl.max_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == lag_last) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          ctrl.out_load = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ----- hdl/bpm_lanes.sv -----
// ----------------------------------------------------------------------------
// bpm_lanes: history registers and lane datapath
// Holds both sample histories, a shifting work copy of the left history, one
// min accumulator per lag and the shared maximum unit.
// ----------------------------------------------------------------------------
module bpm_lanes #(
  parameter int MaxBound = 15
) (
  input  logic            clk,
  input  logic            rst,
  input  bpm_pkg::ctrl_t  ctrl,
  input  bpm_pkg::q_t     left_in,
  input  bpm_pkg::q_t     right_in,
  output bpm_pkg::q_t     result
);

  localparam int LeftDepth = 2 * MaxBound + 1;
  localparam int NumLanes  = MaxBound + 1;

  bpm_pkg::q_t lhist [LeftDepth];
  bpm_pkg::q_t rhist [NumLanes];
  bpm_pkg::q_t work  [LeftDepth];
  bpm_pkg::q_t acc   [NumLanes];
  bpm_pkg::q_t res;

  assign result = res;

  // Sample histories, newest at lag 0
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LeftDepth; k++) lhist[k] <= bpm_pkg::Q_POS_INF;
      for (int k = 0; k < NumLanes; k++)  rhist[k] <= bpm_pkg::Q_NEG_INF;
    end else if (ctrl.load) begin
      lhist[0] <= left_in;
      for (int k = 1; k < LeftDepth; k++) lhist[k] <= lhist[k-1];
      rhist[0] <= right_in;
      for (int k = 1; k < NumLanes; k++)  rhist[k] <= rhist[k-1];
    end
  end

  // Work copy: seed from the shifted history, then advance one lag a step
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      work[0] <= left_in;
      for (int k = 1; k < LeftDepth; k++) work[k] <= lhist[k-1];
    end else if (ctrl.min_step) begin
      for (int k = 0; k < LeftDepth - 1; k++) work[k] <= work[k+1];
      work[LeftDepth-1] <= bpm_pkg::Q_POS_INF;
    end
  end

  // Lane accumulators: seed with the right sample of each lag, take the
  // window minimum, then drain towards lane 0 for the maximum
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc[0] <= right_in;
      for (int k = 1; k < NumLanes; k++) acc[k] <= rhist[k-1];
    end else if (ctrl.min_step) begin
      for (int k = 0; k < NumLanes; k++) acc[k] <= bpm_pkg::q_min(acc[k], work[k]);
    end else if (ctrl.max_step) begin
      for (int k = 0; k < NumLanes - 1; k++) acc[k] <= acc[k+1];
      acc[NumLanes-1] <= bpm_pkg::Q_NEG_INF;
    end
  end

  // Running maximum over the lags
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      res <= bpm_pkg::Q_NEG_INF;
    end else if (ctrl.max_step) begin
      res <= bpm_pkg::q_max(res, acc[0]);
    end
  end

endmodule

// ----- hdl/stl_bounded_precedes_monitor.sv -----
// ----------------------------------------------------------------------------
// Channel   Dir  Width  Contents
// s_axis    in   64     request: left_sample [31:0], right_sample [63:32]
// m_axis    out  32     result: robustness [31:0]
// apb       in   3 / 32 bound_begin at 0x0, bound_end at 0x4
//
// An item with begin <= end goes from one accept to the earliest next accept
// through the accept, which loads, end + 1 lane min steps, end - begin + 1
// steps of the single max unit and one hand-off. With begin > end only the
// accept and the hand-off remain. Bounds above MaxBound are used as MaxBound.
// Reset is synchronous: histories return to +inf / -inf, bounds to 0.
// A stalled m_axis holds the result; the next request is still accepted and
// waits at hand-off until the output register is free.
// ----------------------------------------------------------------------------
module stl_bounded_precedes_monitor #(
  parameter int MaxBound = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // left_sample [31:0], right_sample [63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // robustness [31:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CntW = $clog2(MaxBound + 1);

  logic [3:0]          bound_begin;
  logic [3:0]          bound_end;
  logic [CntW-1:0]     bnd_begin;
  logic [CntW-1:0]     bnd_end;
  logic                idle;
  logic                in_fire;
  logic                out_free;
  bpm_pkg::ctrl_t      ctrl;
  bpm_pkg::q_t         result;
  logic                apb_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign apb_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_begin <= '0;
      bound_end   <= '0;
    end else if (apb_wr) begin
      unique case (paddr[2])
        bpm_pkg::REG_BOUND_BEGIN: bound_begin <= pwdata[3:0];
        bpm_pkg::REG_BOUND_END:   bound_end   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bpm_pkg::REG_BOUND_BEGIN: prdata = {28'd0, bound_begin};
      bpm_pkg::REG_BOUND_END:   prdata = {28'd0, bound_end};
      default:                  prdata = '0;
    endcase
  end

  // Saturate bounds at MaxBound
  assign bnd_begin = ({5'd0, bound_begin} > 9'(MaxBound)) ? CntW'(MaxBound)
                                                          : CntW'(bound_begin);
  assign bnd_end   = ({5'd0, bound_end} > 9'(MaxBound)) ? CntW'(MaxBound)
                                                        : CntW'(bound_end);

  // Input handshake; hold off requests while in reset
  assign s_axis_tready = idle & ~rst;
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  bpm_ctrl #(
    .CntW (CntW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .bnd_begin (bnd_begin),
    .bnd_end   (bnd_end),
    .out_free  (out_free),
    .idle      (idle),
    .ctrl      (ctrl)
  );

  bpm_lanes #(
    .MaxBound (MaxBound)
  ) u_lanes (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .left_in  (s_axis_tdata[31:0]),
    .right_in (s_axis_tdata[63:32]),
    .result   (result)
  );

  // Output register
  assign out_free = ~m_axis_tvalid | m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      m_axis_tdata <= result;
    end
  end

endmodule

// ----- hdl/bpm_checker.sv -----
// ----------------------------------------------------------------------------
// bpm_checker: port-level checks for the bounded precedes monitor
// Watches the stream and configuration ports only; bound to the top level.
// ----------------------------------------------------------------------------
module bpm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        pready
);

  // Not ready again in the cycle after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready straight after an accepted request");

  // A result is never shown in the cycle right after its request
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared without sequencer latency");

  // Stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result dropped or changed");

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && pready)
    else $error("output valid after reset");

endmodule

bind stl_bounded_precedes_monitor bpm_checker u_bpm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .pready        (pready)
);
